// ----- design/btbp_pkg.sv -----
// Package with the shared widths, register indexes and state encoding of the branch predictor.
`default_nettype none
package btbp_pkg;
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned ENTRY_W    = 5;
   localparam int unsigned ENTRIES    = 1 << ENTRY_W;
   localparam int unsigned HIST_W     = 8;
   localparam int unsigned TABLE_SIZE = 1 << HIST_W;
   localparam int unsigned TAG_W      = 30;
   localparam int unsigned CNT_W      = 2;
   localparam int unsigned LADDR_W    = ENTRY_W + HIST_W;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 5;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENTRY_COUNT_LOG2      = 3'd0,
      CSR_HISTORY_LENGTH        = 3'd1,
      CSR_TAG_LENGTH            = 3'd2,
      CSR_INITIAL_COUNTER_STATE = 3'd3,
      CSR_GLOBAL_HISTORY_MODE   = 3'd4,
      CSR_GLOBAL_TABLE_MODE     = 3'd5,
      CSR_SHARE_MODE            = 3'd6
   } csr_index_type;

   // Request actions.
   localparam logic ACT_PREDICT = 1'b0;
   localparam logic ACT_UPDATE  = 1'b1;

   // Share modes.
   localparam logic [1:0] SHARE_PC2  = 2'd1;
   localparam logic [1:0] SHARE_PC16 = 2'd2;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_EXEC   = 5'b00100,
      ST_SWEEP  = 5'b01000,
      ST_REREAD = 5'b10000
   } state_type;
endpackage
`default_nettype wire

// ----- design/btbp_if.sv -----
// Interfaces of the request and response channels of the branch predictor.
`default_nettype none
interface btbp_req_if import btbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] pc;
   logic [ADDR_W-1:0] target_address;
   logic              outcome_taken;
   logic [ADDR_W-1:0] predicted_destination;
   modport source (output valid, action, pc, target_address, outcome_taken,
                   predicted_destination, input ready);
   modport sink (input valid, action, pc, target_address, outcome_taken,
                 predicted_destination, output ready);
endinterface

interface btbp_rsp_if import btbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              predicted_taken;
   logic [ADDR_W-1:0] predicted_target;
   logic [31:0]       flush_count;
   logic [31:0]       branch_count;
   modport source (output valid, predicted_taken, predicted_target, flush_count,
                   branch_count, input ready);
   modport sink (input valid, predicted_taken, predicted_target, flush_count,
                 branch_count, output ready);
endinterface
`default_nettype wire

// ----- design/btb_two_level_branch_predictor_top.sv -----
// Top level of the branch target buffer with two-level direction predictor.
`default_nettype none
// Direct-mapped branch target buffer with two-bit counters, per-entry or shared
// history and per-entry or shared counter tables. A request is taken in the idle state
// and the memories are read at that edge; the result is formed in the next cycle,
// once the response register is free. An update that replaces an entry reads the
// counter again, and with per-entry tables it first rewrites the entry's 256
// counters one a cycle. After reset and after every write to a defined configuration
// register a clearing pass initialises the counter memories; no request is taken
// during it.
module btb_two_level_branch_predictor_top import btbp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   btbp_req_if.sink                   req_ch,
   btbp_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   // Configuration registers.
   logic [2:0] ecl2_ff;
   logic [3:0] hlen_ff;
   logic [4:0] tlen_ff;
   logic [1:0] init_ff;
   logic       ghist_ff;
   logic       gtab_ff;
   logic [1:0] share_ff;
   logic       reinit;

   assign reinit = csr_we && (csr_index <= CSR_SHARE_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         ecl2_ff  <= 3'd0;
         hlen_ff  <= 4'd1;
         tlen_ff  <= 5'd0;
         init_ff  <= 2'd1;
         ghist_ff <= 1'b0;
         gtab_ff  <= 1'b0;
         share_ff <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENTRY_COUNT_LOG2:      ecl2_ff  <= csr_wdata[2:0];
            CSR_HISTORY_LENGTH:        hlen_ff  <= csr_wdata[3:0];
            CSR_TAG_LENGTH:            tlen_ff  <= csr_wdata;
            CSR_INITIAL_COUNTER_STATE: init_ff  <= csr_wdata[1:0];
            CSR_GLOBAL_HISTORY_MODE:   ghist_ff <= csr_wdata[0];
            CSR_GLOBAL_TABLE_MODE:     gtab_ff  <= csr_wdata[0];
            CSR_SHARE_MODE:            share_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Address decoding helpers.
   function automatic logic [ENTRY_W-1:0] entry_of(input logic [ADDR_W-1:0] pc);
      logic [2:0]         n;
      logic [ENTRY_W:0]   m;
      n = (ecl2_ff > 3'(ENTRY_W)) ? 3'(ENTRY_W) : ecl2_ff;
      m = (ENTRY_W+1)'(1) << n;
      m = m - (ENTRY_W+1)'(1);
      return pc[ENTRY_W+1:2] & m[ENTRY_W-1:0];
   endfunction

   function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] pc);
      logic [2:0]        n;
      logic [4:0]        t;
      logic [ADDR_W-1:0] v;
      logic [ADDR_W:0]   m;
      n = (ecl2_ff > 3'(ENTRY_W)) ? 3'(ENTRY_W) : ecl2_ff;
      t = (tlen_ff > 5'(TAG_W)) ? 5'(TAG_W) : tlen_ff;
      v = pc >> (n + 3'd2);
      m = (ADDR_W+1)'(1) << t;
      m = m - (ADDR_W+1)'(1);
      v = v & m[ADDR_W-1:0];
      return v[TAG_W-1:0];
   endfunction

   function automatic logic [HIST_W-1:0] cidx_of(input logic [HIST_W-1:0] h,
                                                 input logic [ADDR_W-1:0] pc);
      logic [3:0]        hb;
      logic [HIST_W:0]   m;
      logic [HIST_W-1:0] i;
      hb = (hlen_ff > 4'(HIST_W)) ? 4'(HIST_W) : hlen_ff;
      m  = (HIST_W+1)'(1) << hb;
      m  = m - (HIST_W+1)'(1);
      i  = h & m[HIST_W-1:0];
      if (gtab_ff && share_ff == SHARE_PC2) begin
         i = i ^ (pc[HIST_W+1:2] & m[HIST_W-1:0]);
      end else if (gtab_ff && share_ff == SHARE_PC16) begin
         i = i ^ (pc[HIST_W+15:16] & m[HIST_W-1:0]);
      end
      return i;
   endfunction

   // Controller and item registers.
   state_type             state_ff;
   logic [LADDR_W-1:0]    clr_ff;
   logic [HIST_W-1:0]     sweep_ff;
   logic                  act_ff;
   logic [ADDR_W-1:0]     pc_ff;
   logic [ADDR_W-1:0]     tgt_ff;
   logic                  taken_ff;
   logic [ADDR_W-1:0]     pdst_ff;
   logic [ENTRY_W-1:0]    e_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [HIST_W-1:0]     hist_ff;
   logic                  missdone_ff;

   // Entry state held in flip-flops.
   logic [ENTRIES-1:0]    valid_ff;
   logic [ENTRIES-1:0]    guess_ff;
   logic [HIST_W-1:0]     ehist_ff [ENTRIES];
   logic [HIST_W-1:0]     shist_ff;
   logic [31:0]           flush_ff;
   logic [31:0]           branch_ff;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_taken_ff;
   logic [ADDR_W-1:0]     rsp_target_ff;

   // Memories and their registered read data.
   logic [TAG_W-1:0]      tag_mem [ENTRIES];
   logic [ADDR_W-1:0]     tgt_mem [ENTRIES];
   logic [CNT_W-1:0]      lcnt_mem [1 << LADDR_W];
   logic [CNT_W-1:0]      scnt_mem [TABLE_SIZE];
   logic [TAG_W-1:0]      tag_rd;
   logic [ADDR_W-1:0]     tgt_rd;
   logic [CNT_W-1:0]      lcnt_rd;
   logic [CNT_W-1:0]      scnt_rd;

   logic                  accept;
   logic                  out_free;
   logic [ENTRY_W-1:0]    req_e;
   logic [HIST_W-1:0]     req_hist;
   logic                  rd_en;
   logic [ENTRY_W-1:0]    rd_e;
   logic [HIST_W-1:0]     rd_cidx;
   logic [HIST_W-1:0]     ex_cidx;
   logic                  hit;
   logic [CNT_W-1:0]      cnt;
   logic [CNT_W-1:0]      cnt_new;
   logic                  fin_update;
   logic                  do_predict;
   logic                  guess;
   logic                  flush_inc;
   logic [HIST_W-1:0]     hist_new;
   logic                  lwe;
   logic [LADDR_W-1:0]    lwa;
   logic [CNT_W-1:0]      lwd;
   logic                  swe;
   logic [HIST_W-1:0]     swa;
   logic [CNT_W-1:0]      swd;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_e        = entry_of(req_ch.pc);
   assign req_hist     = ghist_ff ? shist_ff : ehist_ff[req_e];

   // Read address: from the incoming request, or from the held item on a re-read.
   assign rd_en   = accept || (state_ff == ST_REREAD);
   assign rd_e    = accept ? req_e : e_ff;
   assign rd_cidx = accept ? cidx_of(req_hist, req_ch.pc) : cidx_of(hist_ff, pc_ff);
   assign ex_cidx = cidx_of(hist_ff, pc_ff);

   // Result of the lookup.
   assign hit        = valid_ff[e_ff] && (tag_rd == tag_ff);
   assign cnt        = gtab_ff ? scnt_rd : lcnt_rd;
   assign do_predict = (state_ff == ST_EXEC) && out_free && (act_ff == ACT_PREDICT);
   assign fin_update = (state_ff == ST_EXEC) && out_free && (act_ff == ACT_UPDATE)
                       && (hit || missdone_ff);
   assign guess      = hit && cnt[1];
   assign flush_inc  = (guess_ff[e_ff] != taken_ff)
                       || (taken_ff && (tgt_ff != pdst_ff));
   assign hist_new   = {hist_ff[HIST_W-2:0], taken_ff};

   always_comb begin
      cnt_new = cnt;
      if (taken_ff && cnt != 2'd3) begin
         cnt_new = cnt + 2'd1;
      end else if (!taken_ff && cnt != 2'd0) begin
         cnt_new = cnt - 2'd1;
      end
   end

   // Write ports of the counter memories.
   always_comb begin
      lwe = 1'b0;
      lwa = clr_ff;
      lwd = init_ff;
      swe = 1'b0;
      swa = clr_ff[HIST_W-1:0];
      swd = init_ff;
      if (state_ff == ST_CLEAR) begin
         lwe = 1'b1;
         swe = 1'b1;
      end else if (state_ff == ST_SWEEP) begin
         lwe = 1'b1;
         lwa = {e_ff, sweep_ff};
      end else if (fin_update) begin
         lwe = !gtab_ff;
         lwa = {e_ff, ex_cidx};
         lwd = cnt_new;
         swe = gtab_ff;
         swa = ex_cidx;
         swd = cnt_new;
      end
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (lwe) begin
         lcnt_mem[lwa] <= lwd;
      end
      if (swe) begin
         scnt_mem[swa] <= swd;
      end
      if (fin_update) begin
         tag_mem[e_ff] <= tag_ff;
         tgt_mem[e_ff] <= tgt_ff;
      end
      if (rd_en) begin
         tag_rd  <= tag_mem[rd_e];
         tgt_rd  <= tgt_mem[rd_e];
         lcnt_rd <= lcnt_mem[{rd_e, rd_cidx}];
         scnt_rd <= scnt_mem[rd_cidx];
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_ch.action;
         pc_ff    <= req_ch.pc;
         tgt_ff   <= req_ch.target_address;
         taken_ff <= req_ch.outcome_taken;
         pdst_ff  <= req_ch.predicted_destination;
         e_ff     <= req_e;
         tag_ff   <= tag_of(req_ch.pc);
         hist_ff  <= req_hist;
      end else if ((state_ff == ST_EXEC) && out_free && (act_ff == ACT_UPDATE)
                   && !hit && !missdone_ff && !ghist_ff) begin
         hist_ff <= '0;
      end
   end

   // Controller and entry state.
   always_ff @(posedge clock) begin
      if (reset || reinit) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sweep_ff     <= '0;
         missdone_ff  <= 1'b0;
         valid_ff     <= '0;
         guess_ff     <= '0;
         shist_ff     <= '0;
         flush_ff     <= '0;
         branch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            ehist_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && !do_predict && !fin_update) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + LADDR_W'(1);
               if (clr_ff == {LADDR_W{1'b1}}) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               missdone_ff <= 1'b0;
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (do_predict) begin
                  guess_ff[e_ff] <= guess;
                  rsp_valid_ff   <= 1'b1;
                  rsp_taken_ff   <= guess;
                  rsp_target_ff  <= guess ? tgt_rd : pc_ff + ADDR_W'(4);
                  state_ff       <= ST_IDLE;
               end else if (fin_update) begin
                  valid_ff[e_ff] <= 1'b1;
                  if (ghist_ff) begin
                     shist_ff <= hist_new;
                  end else begin
                     ehist_ff[e_ff] <= hist_new;
                  end
                  if (flush_inc) begin
                     flush_ff <= flush_ff + 32'd1;
                  end
                  branch_ff     <= branch_ff + 32'd1;
                  rsp_valid_ff  <= 1'b1;
                  rsp_taken_ff  <= 1'b0;
                  rsp_target_ff <= '0;
                  state_ff      <= ST_IDLE;
               end else if (out_free) begin
                  // Replacement: with per-entry tables reset the entry's counters, then read again.
                  missdone_ff <= 1'b1;
                  sweep_ff    <= '0;
                  state_ff    <= gtab_ff ? ST_REREAD : ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + HIST_W'(1);
               if (sweep_ff == {HIST_W{1'b1}}) begin
                  state_ff <= ST_REREAD;
               end
            end
            ST_REREAD: begin
               state_ff <= ST_EXEC;
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.predicted_taken  = rsp_taken_ff;
   assign rsp_ch.predicted_target = rsp_target_ff;
   assign rsp_ch.flush_count      = flush_ff;
   assign rsp_ch.branch_count     = branch_ff;
endmodule
`default_nettype wire

// ----- tb/tb_btb_two_level_branch_predictor_top.sv -----
// Self-checking testbench for the two-level branch predictor top level.
`timescale 1ns / 100ps
module tb_btb_two_level_branch_predictor_top import btbp_pkg::*; ();

   localparam int unsigned CYCLE_LIMIT = 4000000;
   localparam int unsigned ITEMS_PER_PHASE = 270;

   typedef struct packed {
      logic        action;
      logic [31:0] pc;
      logic [31:0] target_address;
      logic        outcome_taken;
      logic [31:0] predicted_destination;
   } branch_req_type;

   typedef struct packed {
      logic        predicted_taken;
      logic [31:0] predicted_target;
      logic [31:0] flush_count;
      logic [31:0] branch_count;
   } branch_rsp_type;

   // Scoreboard: keeps its own copy of the predictor and the queue of expected responses.
   class btb_scoreboard;
      bit [2:0]    cfg_entries;
      bit [3:0]    cfg_hist_len;
      bit [4:0]    cfg_tag_len;
      bit [1:0]    cfg_init;
      bit          cfg_ghist;
      bit          cfg_gtable;
      bit [1:0]    cfg_share;
      bit          ent_valid[32];
      bit [29:0]   ent_tag[32];
      bit [31:0]   ent_target[32];
      bit [7:0]    ent_hist[32];
      bit          ent_guess[32];
      bit [1:0]    local_cnt[8192];
      bit [1:0]    shared_cnt[256];
      bit [7:0]    shared_hist;
      bit [31:0]   flushes;
      bit [31:0]   branches;
      branch_rsp_type pending_rsp[$];
      int          errors;
      int          checked;
      int          predicts;
      int          updates;

      function new();
         cfg_entries  = 0;
         cfg_hist_len = 1;
         cfg_tag_len  = 0;
         cfg_init     = 1;
         cfg_ghist    = 0;
         cfg_gtable   = 0;
         cfg_share    = 0;
         errors       = 0;
         checked      = 0;
         predicts     = 0;
         updates      = 0;
         clear_state();
      endfunction

      // Every write to a defined register brings the whole predictor back to its reset state.
      function void clear_state();
         foreach (ent_valid[i]) begin
            ent_valid[i]  = 0;
            ent_tag[i]    = '0;
            ent_target[i] = '0;
            ent_hist[i]   = '0;
            ent_guess[i]  = 0;
         end
         foreach (local_cnt[i]) local_cnt[i] = cfg_init;
         foreach (shared_cnt[i]) shared_cnt[i] = cfg_init;
         shared_hist = '0;
         flushes     = '0;
         branches    = '0;
      endfunction

      function void write_reg(csr_index_type idx, bit [4:0] value);
         case (idx)
            CSR_ENTRY_COUNT_LOG2:      cfg_entries  = value[2:0];
            CSR_HISTORY_LENGTH:        cfg_hist_len = value[3:0];
            CSR_TAG_LENGTH:            cfg_tag_len  = value[4:0];
            CSR_INITIAL_COUNTER_STATE: cfg_init     = value[1:0];
            CSR_GLOBAL_HISTORY_MODE:   cfg_ghist    = value[0];
            CSR_GLOBAL_TABLE_MODE:     cfg_gtable   = value[0];
            CSR_SHARE_MODE:            cfg_share    = value[1:0];
            default: return;
         endcase
         clear_state();
      endfunction

      function int unsigned index_bits();
         int unsigned n;
         n = cfg_entries;
         while (n > 0 && (1 << n) > ENTRIES) n--;
         return n;
      endfunction

      // Counter table index: history, optionally folded with pc bits in gshare fashion.
      function int unsigned table_index(bit [7:0] hist, bit [31:0] pc);
         int unsigned hb;
         bit [31:0]   mask;
         bit [31:0]   i;
         hb   = (cfg_hist_len > HIST_W) ? HIST_W : cfg_hist_len;
         mask = (32'd1 << hb) - 1;
         i    = {24'd0, hist} & mask;
         if (cfg_gtable && cfg_share == SHARE_PC2) i = i ^ ((pc >> 2) & mask);
         else if (cfg_gtable && cfg_share == SHARE_PC16) i = i ^ ((pc >> 16) & mask);
         return i & (TABLE_SIZE - 1);
      endfunction

      // Works out the response to one accepted request and advances the predictor.
      function void note_request(branch_req_type r);
         int unsigned n;
         int unsigned tl;
         int unsigned e;
         int unsigned ci;
         bit [63:0]   tag_mask;
         bit [29:0]   tag;
         bit          hit;
         bit [7:0]    h;
         bit [1:0]    c;
         bit          guess;
         branch_rsp_type x;
         n        = index_bits();
         e        = (r.pc >> 2) & ((32'd1 << n) - 1);
         tl       = (cfg_tag_len > TAG_W) ? TAG_W : cfg_tag_len;
         tag_mask = (64'd1 << tl) - 1;
         tag      = 30'((64'(r.pc) >> (n + 2)) & tag_mask);
         hit      = ent_valid[e] && ent_tag[e] == tag;
         h        = cfg_ghist ? shared_hist : ent_hist[e];
         x        = '0;
         if (r.action == ACT_PREDICT) begin
            predicts++;
            guess = 0;
            if (hit) begin
               ci    = table_index(h, r.pc);
               c     = cfg_gtable ? shared_cnt[ci] : local_cnt[e * TABLE_SIZE + ci];
               guess = c >= 2;
            end
            ent_guess[e]       = guess;
            x.predicted_taken  = guess;
            x.predicted_target = guess ? ent_target[e] : r.pc + 32'd4;
         end else begin
            updates++;
            // A replaced or never-used entry starts afresh in its own history and table, where those are per-entry.
            if (!hit) begin
               if (!cfg_ghist) begin
                  ent_hist[e] = '0;
                  h = '0;
               end
               if (!cfg_gtable)
                  for (int k = 0; k < TABLE_SIZE; k++) local_cnt[e * TABLE_SIZE + k] = cfg_init;
            end
            ent_tag[e]    = tag;
            ent_target[e] = r.target_address;
            ent_valid[e]  = 1;
            ci = table_index(h, r.pc);
            c  = cfg_gtable ? shared_cnt[ci] : local_cnt[e * TABLE_SIZE + ci];
            if (ent_guess[e] != r.outcome_taken) flushes++;
            else if (r.outcome_taken && r.target_address != r.predicted_destination) flushes++;
            branches++;
            h = {h[6:0], r.outcome_taken};
            if (cfg_ghist) shared_hist = h;
            else ent_hist[e] = h;
            if (r.outcome_taken) begin
               if (c < 3) c++;
            end else begin
               if (c > 0) c--;
            end
            if (cfg_gtable) shared_cnt[ci] = c;
            else local_cnt[e * TABLE_SIZE + ci] = c;
         end
         x.flush_count  = flushes;
         x.branch_count = branches;
         pending_rsp.push_back(x);
      endfunction

      // Compares one accepted response with the oldest expectation.
      function void check_response(branch_rsp_type a);
         branch_rsp_type x;
         checked++;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: response with none expected: %h", a);
            return;
         end
         x = pending_rsp.pop_front();
         if (a.predicted_taken !== x.predicted_taken || a.predicted_target !== x.predicted_target
             || a.flush_count !== x.flush_count || a.branch_count !== x.branch_count) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: response %0d taken %b/%b target %h/%h flush %0d/%0d branch %0d/%0d",
                        checked, x.predicted_taken, a.predicted_taken, x.predicted_target,
                        a.predicted_target, x.flush_count, a.flush_count, x.branch_count,
                        a.branch_count);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    no_idle;
   int unsigned           cycles;
   btb_scoreboard         sb;

   btbp_req_if req_ch ();
   btbp_rsp_if rsp_ch ();

   btb_two_level_branch_predictor_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Monitors: note accepted requests and check accepted responses.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request({req_ch.action, req_ch.pc, req_ch.target_address,
                          req_ch.outcome_taken, req_ch.predicted_destination});
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response({rsp_ch.predicted_taken, rsp_ch.predicted_target,
                            rsp_ch.flush_count, rsp_ch.branch_count});
   end

   // Response side: random stalls before each response, none in burst stretches.
   initial begin
      int unsigned stall;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // Sends one request after a random gap and holds it until it is accepted.
   task automatic send_request(branch_req_type r);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid                 <= 1;
      req_ch.action                <= r.action;
      req_ch.pc                    <= r.pc;
      req_ch.target_address        <= r.target_address;
      req_ch.outcome_taken         <= r.outcome_taken;
      req_ch.predicted_destination <= r.predicted_destination;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_fields(logic act, logic [31:0] pc, logic [31:0] tgt, logic taken,
                              logic [31:0] pdst);
      branch_req_type r;
      r = {act, pc, tgt, taken, pdst};
      send_request(r);
   endtask

   // Waits until every response is in, then writes all registers back to back.
   task automatic configure(bit [4:0] ent, bit [4:0] hl, bit [4:0] tl, bit [4:0] ini,
                            bit [4:0] gh, bit [4:0] gt, bit [4:0] sh);
      bit [4:0] vals[7];
      vals = '{ent, hl, tl, ini, gh, gt, sh};
      req_ch.valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(csr_index_type'(i), vals[i]);
      end
      csr_we <= 0;
   endtask

   // Corner requests: address wrap, all-ones and all-zero fields, tag change and flush rules.
   task automatic directed_requests();
      send_fields(ACT_PREDICT, 32'h0000_0000, '0, 0, '0);
      send_fields(ACT_PREDICT, 32'hFFFF_FFFF, '0, 0, '0);
      send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1, 32'h0000_0000);
      send_fields(ACT_PREDICT, 32'hFFFF_FFFC, '0, 0, '0);
      send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
      send_fields(ACT_PREDICT, 32'hFFFF_FFFC, '0, 0, '0);
      send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1, 32'h1234_5678);
      send_fields(ACT_PREDICT, 32'hFFFF_FFFC, '0, 0, '0);
      send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'h0000_0000, 0, 32'h0000_0000);
      send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'h0000_0000, 0, 32'hFFFF_FFFF);
      send_fields(ACT_PREDICT, 32'hFFFF_FFFC, '0, 0, '0);
      // Same index, other tag: the entry is replaced.
      send_fields(ACT_UPDATE, 32'h0000_007C, 32'h0000_0040, 1, 32'h0000_0040);
      send_fields(ACT_PREDICT, 32'hFFFF_FFFC, '0, 0, '0);
      send_fields(ACT_PREDICT, 32'h0000_007C, '0, 0, '0);
      send_fields(ACT_UPDATE, 32'h0000_007C, 32'h0000_0040, 1, 32'h0000_0040);
      send_fields(ACT_PREDICT, 32'h0000_007C, '0, 0, '0);
      send_fields(ACT_UPDATE, 32'h0000_0000, 32'hAAAA_5555, 1, 32'h5555_AAAA);
      send_fields(ACT_PREDICT, 32'h0000_0000, '0, 0, '0);
   endtask

   // Mostly predict/update pairs over a small pool of branches, with random noise mixed in.
   task automatic random_requests(int unsigned count);
      bit [31:0]   pool_pc[8];
      bit [31:0]   pool_tgt[8];
      int unsigned bias[8];
      int unsigned k;
      int unsigned p;
      bit          taken;
      bit [31:0]   pdst;
      foreach (pool_pc[i]) begin
         pool_pc[i]  = $urandom();
         pool_tgt[i] = $urandom();
         bias[i]     = $urandom_range(0, 10);
      end
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         k = $urandom_range(0, 9);
         if (k < 7) begin
            p     = $urandom_range(0, 7);
            taken = $urandom_range(0, 9) < bias[p];
            case ($urandom_range(0, 3))
               0:       pdst = pool_pc[p] + 32'd4;
               1:       pdst = $urandom();
               default: pdst = pool_tgt[p];
            endcase
            send_fields(ACT_PREDICT, pool_pc[p], $urandom(), 1'($urandom_range(0, 1)),
                        $urandom());
            send_fields(ACT_UPDATE, pool_pc[p], pool_tgt[p], taken, pdst);
            i++;
         end else begin
            send_fields(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                        1'($urandom_range(0, 1)), $urandom());
         end
      end
   endtask

   // Main sequence: reset, then several register settings, each followed by traffic.
   initial begin
      sb                           = new();
      cycles                       = 0;
      no_idle                      = 0;
      reset                        = 1;
      csr_we                       = 0;
      csr_index                    = '0;
      csr_wdata                    = '0;
      req_ch.valid                 = 0;
      req_ch.action                = ACT_PREDICT;
      req_ch.pc                    = '0;
      req_ch.target_address        = '0;
      req_ch.outcome_taken         = 0;
      req_ch.predicted_destination = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      configure(0, 1, 0, 1, 0, 0, 0);
      random_requests(ITEMS_PER_PHASE);
      configure(5, 8, 30, 3, 0, 1, SHARE_PC2);
      directed_requests();
      random_requests(ITEMS_PER_PHASE);
      configure(2, 4, 3, 0, 1, 1, SHARE_PC16);
      random_requests(ITEMS_PER_PHASE);
      configure(7, 15, 31, 2, 1, 0, 3);
      random_requests(ITEMS_PER_PHASE);
      configure(3, 0, 5, 0, 0, 1, SHARE_PC2);
      random_requests(ITEMS_PER_PHASE);
      configure(5, 8, 30, 2, 0, 0, 0);
      random_requests(ITEMS_PER_PHASE);

      // Drain the response queue, then allow for the slowest replacement.
      req_ch.valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("Run covered %0d predicts and %0d updates over six register settings.",
               sb.predicts, sb.updates);
      $display("Responses checked: %0d, mismatches: %0d.", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
